[rtl/dtpq_pkg.sv]
// ----------------------------------------------------------------------------
// dtpq_pkg: shared types and constants of the drop-tail packet queue
// Operation and status codes, register indexes, reset values, the command
// record passed from the front end to the back end, and the back-end states.
// ----------------------------------------------------------------------------
package dtpq_pkg;

  // Default descriptor storage depth
  localparam int DEF_QUEUE_DEPTH = 128;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 16;
  localparam int STATUS_W = 2;
  localparam int PKTS_W   = 8;
  localparam int BYTES_W  = 24;
  localparam int DESC_W   = HANDLE_W + LENGTH_W;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PKTS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES  = 2'd2;

  localparam logic               RST_LIMIT_MODE = 1'b0;
  localparam logic [PKTS_W-1:0]  RST_MAX_PKTS   = 8'd100;
  localparam logic [BYTES_W-1:0] RST_MAX_BYTES  = 24'd6553500;

  // Limit modes
  localparam logic MODE_PACKETS = 1'b0;
  localparam logic MODE_BYTES   = 1'b1;

  // Opcodes as they arrive on the input stream
  localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HEAD     = 2'd3;

  // Command kinds after classification (unused opcode acts as a peek)
  typedef enum logic [1:0] {
    KIND_ENQ,
    KIND_DEQ,
    KIND_PEEK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } cmd_t;

  // Live configuration handed to the back end
  typedef struct packed {
    logic               limit_mode;
    logic [PKTS_W-1:0]  max_pkts;
    logic [BYTES_W-1:0] max_bytes;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

[rtl/dtpq_ram.sv]
// ----------------------------------------------------------------------------
// dtpq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/dtpq_front.sv]
// ----------------------------------------------------------------------------
// dtpq_front: input front end of the drop-tail packet queue
// Accepts input transactions, decodes the opcode into a command kind and
// holds commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dtpq_front
  import dtpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [LENGTH_W-1:0] in_length,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_pop
);

  cmd_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;
  cmd_t       decoded;

  always_comb begin
    decoded.handle = in_handle;
    decoded.length = in_length;
    case (in_opcode)
      OP_ENQUEUE: decoded.kind = KIND_ENQ;
      OP_DEQUEUE: decoded.kind = KIND_DEQ;
      default:    decoded.kind = KIND_PEEK;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

[rtl/dtpq_back.sv]
// ----------------------------------------------------------------------------
// dtpq_back: back end of the drop-tail packet queue
// Applies admission, keeps pointers, count and byte total, drives the
// descriptor RAM and holds the result in an output register.
// ----------------------------------------------------------------------------
module dtpq_back
  import dtpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] res_status,
  output logic [HANDLE_W-1:0] res_handle,
  output logic [LENGTH_W-1:0] res_length,
  output logic [PKTS_W-1:0]   res_pkts,
  output logic [BYTES_W-1:0]  res_bytes
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > PKTS_W) ? CNT_W : PKTS_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  back_state_t state_r, state_nxt;

  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  cmd_kind_t          kind_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, handle_nxt;
  logic [LENGTH_W-1:0] out_length_r, length_nxt;
  logic [PKTS_W-1:0]   out_pkts_r;
  logic [BYTES_W-1:0]  out_bytes_r;

  logic               slot_free, go, load, drop;
  logic               ram_we, ram_re;
  logic [DESC_W-1:0]  ram_rdata;
  logic [BYTES_W:0]   byte_sum;
  logic [CMP_W-1:0]   cnt_ext;

  assign slot_free = !out_valid_r || res_ready;
  assign go        = cmd_valid && slot_free;
  assign byte_sum  = {1'b0, bytes_r} + (BYTES_W+1)'(cmd.length);
  assign cnt_ext   = CMP_W'(cnt_r);

  always_comb begin
    drop = 1'b0;
    if (cnt_r == FULL_CNT) begin
      drop = 1'b1;
    end else if (cfg.limit_mode == MODE_PACKETS) begin
      drop = (cnt_ext >= CMP_W'(cfg.max_pkts));
    end else begin
      drop = (byte_sum >= {1'b0, cfg.max_bytes});
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (go && cmd.kind != KIND_ENQ && cnt_r != '0) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    status_nxt = ST_EMPTY;
    handle_nxt = '0;
    length_nxt = '0;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    bytes_nxt  = bytes_r;
    case (state_r)
      BK_IDLE: begin
        if (go) begin
          cmd_pop = 1'b1;
          if (cmd.kind == KIND_ENQ) begin
            load = 1'b1;
            if (drop) begin
              status_nxt = ST_DROPPED;
            end else begin
              status_nxt = ST_ENQUEUED;
              ram_we     = 1'b1;
              wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
              cnt_nxt    = cnt_r + CNT_W'(1);
              bytes_nxt  = byte_sum[BYTES_W-1:0];
            end
          end else if (cnt_r == '0) begin
            load       = 1'b1;
            status_nxt = ST_EMPTY;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      BK_READ: begin
        load       = 1'b1;
        status_nxt = ST_HEAD;
        handle_nxt = ram_rdata[DESC_W-1:LENGTH_W];
        length_nxt = ram_rdata[LENGTH_W-1:0];
        if (kind_r == KIND_DEQ) begin
          rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
          cnt_nxt    = cnt_r - CNT_W'(1);
          bytes_nxt  = bytes_r - BYTES_W'(ram_rdata[LENGTH_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      bytes_r  <= bytes_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      kind_r <= cmd.kind;
    end
    if (load) begin
      out_status_r <= status_nxt;
      out_handle_r <= handle_nxt;
      out_length_r <= length_nxt;
      out_pkts_r   <= PKTS_W'(CMP_W'(cnt_nxt));
      out_bytes_r  <= bytes_nxt;
    end
  end

  dtpq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_ptr_r),
    .wr_data ({cmd.handle, cmd.length}),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  assign res_valid  = out_valid_r;
  assign res_status = out_status_r;
  assign res_handle = out_handle_r;
  assign res_length = out_length_r;
  assign res_pkts   = out_pkts_r;
  assign res_bytes  = out_bytes_r;

endmodule

[rtl/drop_tail_packet_queue.sv]
// ----------------------------------------------------------------------------
// drop_tail_packet_queue: FIFO of packet descriptors with drop-tail admission
//
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  opcode, handle, length
// out_     master     out_tvalid/out_tready status, head, packets, bytes
// cfg_     write      cfg_wr_en            register index and data
//
// Enqueue, and dequeue or peek on an empty queue, finish in state BK_IDLE;
// dequeue and peek on a stored head go on to BK_READ, for the registered read
// of the descriptor RAM. One operation is in the back end at a time; a
// two-entry command queue in front keeps accepting meanwhile.
// Reset (rst_n, synchronous) clears pointers, count, byte total and all
// handshake state; the descriptor RAM is not cleared and no clearing pass runs.
// A stalled output holds its result; the back end waits for the output
// register to free before starting the next transaction.
// ----------------------------------------------------------------------------
module drop_tail_packet_queue
  import dtpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] opcode, [17:2] packet_handle, [33:18] packet_length, [39:34] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [17:2] head_handle, [33:18] head_length,
  // [41:34] packets_held, [65:42] bytes_held, [71:66] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // Configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  cfg_t cfg_r;

  logic                cmd_valid, cmd_pop;
  cmd_t                cmd;
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [LENGTH_W-1:0] res_length;
  logic [PKTS_W-1:0]   res_pkts;
  logic [BYTES_W-1:0]  res_bytes;

  // Register file: latch the written field, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_mode <= RST_LIMIT_MODE;
      cfg_r.max_pkts   <= RST_MAX_PKTS;
      cfg_r.max_bytes  <= RST_MAX_BYTES;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LIMIT_MODE: cfg_r.limit_mode <= cfg_wr_data[0];
        REG_MAX_PKTS:   cfg_r.max_pkts   <= cfg_wr_data[PKTS_W-1:0];
        REG_MAX_BYTES:  cfg_r.max_bytes  <= cfg_wr_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify transactions
  dtpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tdata[1:0]),
    .in_handle (in_tdata[17:2]),
    .in_length (in_tdata[33:18]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: admission, storage and result
  dtpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_handle (res_handle),
    .res_length (res_length),
    .res_pkts   (res_pkts),
    .res_bytes  (res_bytes)
  );

  // Pack the result, padding to whole bytes
  assign out_tdata = {6'd0, res_bytes, res_pkts, res_length, res_handle, res_status};

  // An empty queue reports zero packets, zero bytes and no head
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status == ST_EMPTY)
      |-> (res_pkts == '0 && res_bytes == '0 && res_handle == '0))
    else $error("empty result with nonzero count, byte total or handle");

  // Enqueue results never carry a head descriptor
  a_enq_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_status == ST_ENQUEUED || res_status == ST_DROPPED))
      |-> (res_handle == '0 && res_length == '0))
    else $error("enqueue result carries head fields");

  // No result is pending right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
